>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check out of reset
`define CLP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check at every edge, reset included
`define CLP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/clp_pkg.sv
// ----------------------------------------------------------------------------
// clp_pkg
// Shared constants, register indexes and controller/datapath structs.
// ----------------------------------------------------------------------------
package clp_pkg;

	localparam int MAXD_W   = 18;
	localparam int WARN_W   = 12;
	localparam int ITL_W    = 16;
	localparam int ENERGY_W = 12;
	localparam int RUN_W    = 16;
	localparam int LIMIT_W  = 17;
	localparam int GAIN_W   = 16;
	localparam int QUO_W    = 17;
	localparam int CFG_IDX_W = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
	localparam logic [RUN_W-1:0]   RUN_MAX   = '1;

	localparam logic [MAXD_W-1:0] MAXD_RST = 18'd40000;
	localparam logic [WARN_W-1:0] WARN_RST = 12'd672;
	localparam logic [ITL_W-1:0]  ITL_RST  = 16'd100;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WARN      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_LIMIT = 2'd2;

	localparam logic [1:0] MUL_RATIO = 2'd0;
	localparam logic [1:0] MUL_GAIN  = 2'd1;
	localparam logic [1:0] MUL_WHEEL = 2'd2;

	typedef struct packed {
		logic       capture;
		logic       prep;
		logic       div_start;
		logic       div_energy;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       set_limit;
		logic       check;
		logic       store_wheel;
		logic [1:0] wheel;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic need_ratio;
		logic scale;
		logic div_busy;
		logic div_done;
		logic out_free;
	} sts_t;

	function automatic logic [LIMIT_W-1:0] sat_limit(input logic [MAXD_W-1:0] v);
		return (v[MAXD_W-1:LIMIT_W] != '0) ? LIMIT_MAX : v[LIMIT_W-1:0];
	endfunction

endpackage

>>> rtl/clp_div.sv
// ----------------------------------------------------------------------------
// clp_div
// Restoring divider, one quotient bit per cycle, fixed quotient width.
// Dividend must stay below divisor * 2^QUO_W.
// ----------------------------------------------------------------------------
module clp_div #(
	parameter int DVW = 34,
	parameter int DSW = 18
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [DVW-1:0]            dividend,
	input  logic [DSW-1:0]            divisor,
	output logic [clp_pkg::QUO_W-1:0] quotient,
	output logic                      busy,
	output logic                      done
);
	localparam int QW = clp_pkg::QUO_W;
	localparam int CW = $clog2(QW + 1);

	logic [DSW-1:0] rem_q;
	logic [DSW-1:0] dsr_q;
	logic [QW-1:0]  lo_q;
	logic [QW-1:0]  quo_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [DVW-1:0] hi_c;
	logic [DSW:0]   trial_c;
	logic [DSW:0]   diff_c;
	logic           ge_c;

	assign hi_c    = dividend >> QW;
	assign trial_c = {rem_q, lo_q[QW-1]};
	assign ge_c    = trial_c >= {1'b0, dsr_q};
	assign diff_c  = trial_c - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= hi_c[DSW-1:0];
			dsr_q <= divisor;
			lo_q  <= dividend[QW-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge_c ? diff_c[DSW-1:0] : trial_c[DSW-1:0];
			lo_q  <= {lo_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge_c};
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

>>> rtl/clp_dp.sv
// ----------------------------------------------------------------------------
// clp_dp
// Datapath: config registers, magnitudes and sum, limit state, shared
// multiplier, shared divider, result and output registers.
// ----------------------------------------------------------------------------
module clp_dp #(
	parameter int DRIVE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  clp_pkg::cmd_t                 cmd,
	output clp_pkg::sts_t                 sts,
	input  logic                          cfg_we,
	input  logic [clp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [clp_pkg::MAXD_W-1:0]    cfg_data,
	input  logic [4*DRIVE_WIDTH-1:0]      drives,
	input  logic                          referee_valid,
	input  logic [clp_pkg::ENERGY_W-1:0]  buffer_energy,
	output logic [4*DRIVE_WIDTH-1:0]      limited,
	output logic                          was_scaled,
	output logic                          out_valid,
	input  logic                          out_ready
);
	localparam int DW   = DRIVE_WIDTH;
	localparam int SW   = DW + 2;
	localparam int MA   = (DW > clp_pkg::GAIN_W) ? DW : clp_pkg::GAIN_W;
	localparam int MB   = clp_pkg::MAXD_W;
	localparam int PW   = MA + MB;
	localparam int DSW  = (SW > clp_pkg::WARN_W) ? SW : clp_pkg::WARN_W;
	localparam int QX   = (DW > clp_pkg::QUO_W) ? DW : clp_pkg::QUO_W;
	localparam int CMPW = (SW > clp_pkg::LIMIT_W) ? SW : clp_pkg::LIMIT_W;
	localparam int GW   = clp_pkg::GAIN_W;

	logic [clp_pkg::MAXD_W-1:0]   max_q;
	logic [clp_pkg::WARN_W-1:0]   warn_q;
	logic [clp_pkg::ITL_W-1:0]    itl_q;
	logic [clp_pkg::RUN_W-1:0]    run_q;
	logic [clp_pkg::LIMIT_W-1:0]  limit_q;
	logic                         out_valid_q;

	logic [DW-1:0]                raw_q [4];
	logic [DW-1:0]                mag_q [4];
	logic [DW-1:0]                res_q [4];
	logic                         valid_q;
	logic [clp_pkg::ENERGY_W-1:0] energy_q;
	logic [SW-1:0]                sum_q;
	logic [PW-1:0]                prod_q;
	logic                         scaled_q;
	logic [4*DW-1:0]              out_data_q;
	logic                         out_scaled_q;

	logic [DW-1:0]                mag_c [4];
	logic [SW-1:0]                sum_c;
	logic [clp_pkg::RUN_W-1:0]    run_inc_c;
	logic                         energy_low_c;
	logic                         scale_c;
	logic [MA-1:0]                mul_a;
	logic [MB-1:0]                mul_b;
	logic [PW-1:0]                mul_p;
	logic [PW-1:0]                div_dvd;
	logic [DSW-1:0]               div_dsr;
	logic [clp_pkg::QUO_W-1:0]    div_quo;
	logic                         div_busy;
	logic                         div_done;
	logic [QX-1:0]                quo_x;
	logic [DW-1:0]                m_c;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag_c[i] = raw_q[i][DW-1] ? (DW'(0) - raw_q[i]) : raw_q[i];
		end
	end

	assign sum_c = SW'(mag_c[0]) + SW'(mag_c[1]) + SW'(mag_c[2]) + SW'(mag_c[3]);

	assign run_inc_c    = (run_q == clp_pkg::RUN_MAX) ? run_q : run_q + 1'b1;
	assign energy_low_c = energy_q < warn_q;
	assign scale_c      = CMPW'(sum_q) > CMPW'(limit_q);

	always_comb begin
		case (cmd.mul_sel)
			clp_pkg::MUL_RATIO: begin
				mul_a = MA'(div_quo[GW-1:0]);
				mul_b = MB'(div_quo[GW-1:0]);
			end
			clp_pkg::MUL_GAIN: begin
				mul_a = MA'(prod_q[2*GW-1:GW]);
				mul_b = max_q;
			end
			clp_pkg::MUL_WHEEL: begin
				mul_a = MA'(mag_q[cmd.wheel]);
				mul_b = MB'(limit_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign div_dvd = cmd.div_energy ? PW'({energy_q, GW'(0)}) : prod_q;
	assign div_dsr = cmd.div_energy ? DSW'(warn_q) : DSW'(sum_q);

	clp_div #(
		.DVW(PW),
		.DSW(DSW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(div_dvd),
		.divisor (div_dsr),
		.quotient(div_quo),
		.busy    (div_busy),
		.done    (div_done)
	);

	assign quo_x = QX'(div_quo);
	assign m_c   = quo_x[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= clp_pkg::MAXD_RST;
			warn_q      <= clp_pkg::WARN_RST;
			itl_q       <= clp_pkg::ITL_RST;
			run_q       <= '0;
			limit_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					clp_pkg::REG_MAX_TOTAL: max_q  <= cfg_data;
					clp_pkg::REG_WARN:      warn_q <= cfg_data[clp_pkg::WARN_W-1:0];
					clp_pkg::REG_INV_LIMIT: itl_q  <= cfg_data[clp_pkg::ITL_W-1:0];
					default: ;
				endcase
			end
			if (cmd.prep) begin
				if (valid_q) begin
					run_q <= '0;
					if (!energy_low_c) begin
						limit_q <= clp_pkg::sat_limit(max_q);
					end
				end else begin
					run_q <= run_inc_c;
					if (run_inc_c > itl_q) begin
						limit_q <= clp_pkg::sat_limit(max_q >> 2);
					end
				end
			end
			if (cmd.set_limit) begin
				limit_q <= clp_pkg::sat_limit(prod_q[GW+clp_pkg::MAXD_W-1:GW]);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int i = 0; i < 4; i++) begin
				raw_q[i] <= drives[i*DW +: DW];
			end
			valid_q  <= referee_valid;
			energy_q <= buffer_energy;
		end
		if (cmd.prep) begin
			for (int i = 0; i < 4; i++) begin
				mag_q[i] <= mag_c[i];
			end
			sum_q <= sum_c;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.check) begin
			scaled_q <= scale_c;
			if (!scale_c) begin
				for (int i = 0; i < 4; i++) begin
					res_q[i] <= raw_q[i];
				end
			end
		end
		if (cmd.store_wheel) begin
			res_q[cmd.wheel] <= raw_q[cmd.wheel][DW-1] ? (DW'(0) - m_c) : m_c;
		end
		if (cmd.load_out) begin
			for (int i = 0; i < 4; i++) begin
				out_data_q[i*DW +: DW] <= res_q[i];
			end
			out_scaled_q <= scaled_q;
		end
	end

	assign sts.need_ratio = valid_q & energy_low_c;
	assign sts.scale      = scale_c;
	assign sts.div_busy   = div_busy;
	assign sts.div_done   = div_done;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign limited    = out_data_q;
	assign was_scaled = out_scaled_q;
	assign out_valid  = out_valid_q;

endmodule

>>> rtl/clp_ctrl.sv
// ----------------------------------------------------------------------------
// clp_ctrl
// Sequencer: limit update, then per-wheel multiply and divide when the
// request exceeds the limit.
// ----------------------------------------------------------------------------
module clp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  clp_pkg::sts_t sts,
	output clp_pkg::cmd_t cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PREP  = 4'd1;
	localparam logic [3:0] S_EDIV  = 4'd2;
	localparam logic [3:0] S_EWAIT = 4'd3;
	localparam logic [3:0] S_MULG  = 4'd4;
	localparam logic [3:0] S_MULL  = 4'd5;
	localparam logic [3:0] S_SETL  = 4'd6;
	localparam logic [3:0] S_CHK   = 4'd7;
	localparam logic [3:0] S_MULW  = 4'd8;
	localparam logic [3:0] S_WDIV  = 4'd9;
	localparam logic [3:0] S_WWAIT = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] wheel_q;

	always_comb begin
		cmd       = '0;
		cmd.wheel = wheel_q;
		state_d   = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = sts.need_ratio ? S_EDIV : S_CHK;
			end
			S_EDIV: begin
				cmd.div_start  = 1'b1;
				cmd.div_energy = 1'b1;
				state_d        = S_EWAIT;
			end
			S_EWAIT: begin
				if (sts.div_done) begin
					state_d = S_MULG;
				end
			end
			S_MULG: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = clp_pkg::MUL_RATIO;
				state_d     = S_MULL;
			end
			S_MULL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = clp_pkg::MUL_GAIN;
				state_d     = S_SETL;
			end
			S_SETL: begin
				cmd.set_limit = 1'b1;
				state_d       = S_CHK;
			end
			S_CHK: begin
				cmd.check = 1'b1;
				state_d   = sts.scale ? S_MULW : S_DONE;
			end
			S_MULW: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = clp_pkg::MUL_WHEEL;
				state_d     = S_WDIV;
			end
			S_WDIV: begin
				cmd.div_start = 1'b1;
				state_d       = S_WWAIT;
			end
			S_WWAIT: begin
				if (sts.div_done) begin
					cmd.store_wheel = 1'b1;
					state_d         = (wheel_q == '1) ? S_DONE : S_MULW;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wheel_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				wheel_q <= '0;
			end else if (cmd.store_wheel) begin
				wheel_q <= wheel_q + 1'b1;
			end
		end
	end

	assign in_ready = state_q == S_IDLE;

endmodule

>>> rtl/chassis_power_limiter_core.sv
// ----------------------------------------------------------------------------
// chassis_power_limiter_core
// Power limiter for four wheel drive commands: energy-based total limit,
// proportional rescale of the commands when their magnitude sum exceeds it.
//
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: 4 drives, energy; tuser: valid
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: 4 limited drives; tuser: scaled
// cfg       in         cfg_we                       cfg_idx, cfg_data
//
// One request at a time. The 17-step shared divider runs for the limit
// division when energy is below the warning level and once per wheel when
// rescaling. Reset clears state, the limit and the invalid counter; config
// returns to defaults. A stalled result waits in the output register; the
// next request is still taken and processed, and its result waits in S_DONE
// until the output register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chassis_power_limiter_core #(
	parameter int DRIVE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// drive_front_left, drive_front_right, drive_rear_left, drive_rear_right,
	// buffer_energy, zero fill
	input  logic [((4*DRIVE_WIDTH+clp_pkg::ENERGY_W+7)/8)*8-1:0] s_axis_tdata,
	// referee_valid
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// limited_front_left, limited_front_right, limited_rear_left,
	// limited_rear_right, zero fill
	output logic [((4*DRIVE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// was_scaled
	output logic                          m_axis_tuser,
	input  logic                          cfg_we,
	input  logic [clp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [clp_pkg::MAXD_W-1:0]    cfg_data
);
	localparam int DW     = DRIVE_WIDTH;
	localparam int OUT_TW = ((4*DW + 7) / 8) * 8;

	clp_pkg::cmd_t   cmd;
	clp_pkg::sts_t   sts;
	logic [4*DW-1:0] limited;

	clp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	clp_dp #(
		.DRIVE_WIDTH(DW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.drives       (s_axis_tdata[4*DW-1:0]),
		.referee_valid(s_axis_tuser),
		.buffer_energy(s_axis_tdata[4*DW +: clp_pkg::ENERGY_W]),
		.limited      (limited),
		.was_scaled   (m_axis_tuser),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready)
	);

	assign m_axis_tdata = OUT_TW'(limited);

	`CLP_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken while busy")
	`CLP_ASSERT(a_div_no_restart, cmd.div_start |-> !sts.div_busy, "divider restarted mid-run")
	`CLP_ASSERT(a_load_when_free, cmd.load_out |=> m_axis_tvalid, "result load lost")
	`CLP_ASSERT_ALWAYS(a_rst_no_out, !arst_n |-> !m_axis_tvalid, "result valid during reset")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks chassis_power_limiter_core against its own cycle-free model of the
// energy-based limit and the proportional rescale. A table of directed ticks
// runs first: reset state, field extremes, zero and full energy, fallback
// after invalid runs. Short invalid runs against large tolerances follow.
// Random phases follow, each with its own register setting.
// Requests come in bursts with random gaps; the result side stalls on its own
// pattern. Every result is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int DW        = 16;
	localparam int SDATA_W   = ((4*DW+clp_pkg::ENERGY_W+7)/8)*8;
	localparam int MDATA_W   = ((4*DW+7)/8)*8;
	localparam int CYCLE_CAP = 5_000_000;
	localparam logic [clp_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [3:0][DW-1:0]            drive;
		logic                          referee_valid;
		logic [clp_pkg::ENERGY_W-1:0]  energy;
	} tick_t;

	typedef struct packed {
		logic [3:0][DW-1:0] cmd;
		logic               was_scaled;
	} limited_t;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                   kind;
		tick_t                       tick;
		logic                        known;
		limited_t                    want;
		logic [clp_pkg::MAXD_W-1:0]  max_v;
		logic [clp_pkg::MAXD_W-1:0]  warn_v;
		logic [clp_pkg::MAXD_W-1:0]  itl_v;
	} row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_HOLD, RX_CHOP} rx_mode_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b1;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [SDATA_W-1:0]            s_axis_tdata = '0;
	logic                          s_axis_tuser = 1'b0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [MDATA_W-1:0]            m_axis_tdata;
	logic                          m_axis_tuser;
	logic                          cfg_we = 1'b0;
	logic [clp_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [clp_pkg::MAXD_W-1:0]    cfg_data = '0;

	logic [clp_pkg::MAXD_W-1:0]    cap_max   = clp_pkg::MAXD_RST;
	logic [clp_pkg::WARN_W-1:0]    warn_lvl  = clp_pkg::WARN_RST;
	logic [clp_pkg::ITL_W-1:0]     tol_ticks = clp_pkg::ITL_RST;
	logic [clp_pkg::RUN_W-1:0]     run_count = '0;
	logic [clp_pkg::LIMIT_W-1:0]   cur_limit = '0;

	limited_t limited_q [$];
	row_t     dir_rows [$];
	string    wheel_name [4] = '{"limited_front_left", "limited_front_right",
		"limited_rear_left", "limited_rear_right"};
	int       fails = 0;
	int       cycles = 0;
	int       burst_left = 0;
	int       inv_left = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;

	chassis_power_limiter_core #(.DRIVE_WIDTH(DW)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic limited_t limit_drives(input tick_t t);
		logic [63:0] mag [4];
		logic        neg [4];
		logic [63:0] sum;
		logic [63:0] ratio;
		logic [63:0] next_lim;
		logic [63:0] m;
		logic        upd;
		logic        scale;
		limited_t    r;
		int          w;
		sum      = '0;
		upd      = 1'b0;
		next_lim = '0;
		for (w = 0; w < 4; w++) begin
			neg[w] = t.drive[w][DW-1];
			mag[w] = neg[w] ? ((64'd1 << DW) - 64'(t.drive[w])) : 64'(t.drive[w]);
			sum += mag[w];
		end
		if (!t.referee_valid) begin
			if (run_count != clp_pkg::RUN_MAX)
				run_count++;
			if (run_count > tol_ticks) begin
				upd      = 1'b1;
				next_lim = 64'(cap_max) >> 2;
			end
		end else begin
			run_count = '0;
			upd       = 1'b1;
			if (t.energy < warn_lvl) begin
				ratio    = (64'(t.energy) << 16) / 64'(warn_lvl);
				next_lim = (((ratio * ratio) >> 16) * 64'(cap_max)) >> 16;
			end else begin
				next_lim = 64'(cap_max);
			end
		end
		if (upd)
			cur_limit = (next_lim > 64'(clp_pkg::LIMIT_MAX)) ? clp_pkg::LIMIT_MAX :
				next_lim[clp_pkg::LIMIT_W-1:0];
		scale = sum > 64'(cur_limit);
		for (w = 0; w < 4; w++) begin
			m = scale ? (mag[w] * 64'(cur_limit)) / sum : mag[w];
			r.cmd[w] = neg[w] ? DW'(~m + 64'd1) : DW'(m);
		end
		r.was_scaled = scale;
		return r;
	endfunction

	function automatic row_t tick_row(input int fl, input int fr, input int rl, input int rr,
		input int ok, input int e);
		row_t r;
		r                    = '0;
		r.kind               = ROW_TICK;
		r.tick.drive[0]      = DW'(fl);
		r.tick.drive[1]      = DW'(fr);
		r.tick.drive[2]      = DW'(rl);
		r.tick.drive[3]      = DW'(rr);
		r.tick.referee_valid = ok[0];
		r.tick.energy        = clp_pkg::ENERGY_W'(e);
		return r;
	endfunction

	function automatic row_t tick_row_known(input int fl, input int fr, input int rl,
		input int rr, input int ok, input int e, input int e_fl, input int e_fr,
		input int e_rl, input int e_rr, input int e_sc);
		row_t r;
		r                  = tick_row(fl, fr, rl, rr, ok, e);
		r.known            = 1'b1;
		r.want.cmd[0]      = DW'(e_fl);
		r.want.cmd[1]      = DW'(e_fr);
		r.want.cmd[2]      = DW'(e_rl);
		r.want.cmd[3]      = DW'(e_rr);
		r.want.was_scaled  = e_sc[0];
		return r;
	endfunction

	function automatic row_t cfg_row(input int mx, input int wn, input int it);
		row_t r;
		r        = '0;
		r.kind   = ROW_CFG;
		r.max_v  = clp_pkg::MAXD_W'(mx);
		r.warn_v = clp_pkg::MAXD_W'(wn);
		r.itl_v  = clp_pkg::MAXD_W'(it);
		return r;
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		int    w;
		int    e;
		for (w = 0; w < 4; w++) begin
			case ($urandom_range(0, 5))
				0: t.drive[w] = '0;
				1: t.drive[w] = {1'b0, {(DW-1){1'b1}}};
				2: t.drive[w] = {1'b1, {(DW-1){1'b0}}};
				3: t.drive[w] = DW'($urandom_range(0, 600)) - DW'(300);
				default: t.drive[w] = DW'($urandom);
			endcase
		end
		if (inv_left == 0 && $urandom_range(0, 9) == 0)
			inv_left = $urandom_range(1, (tol_ticks < 30) ? int'(tol_ticks) + 3 : 30);
		t.referee_valid = (inv_left == 0);
		if (inv_left != 0)
			inv_left--;
		case ($urandom_range(0, 6))
			0: e = 0;
			1: e = 4095;
			2: e = int'(warn_lvl) - 1 + int'($urandom_range(0, 2));
			3: e = $urandom_range(0, warn_lvl);
			default: e = $urandom_range(0, 4095);
		endcase
		if (e < 0)
			e = 0;
		if (e > 4095)
			e = 4095;
		t.energy = clp_pkg::ENERGY_W'(e);
		return t;
	endfunction

	task automatic send_tick(input tick_t t, input logic known, input limited_t want);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0)
				gap = $urandom_range(0, 60);
			else
				gap = $urandom_range(0, 4);
			burst_left = $urandom_range(1, 32);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(SDATA_W-4*DW-clp_pkg::ENERGY_W){1'b0}}, t.energy, t.drive};
		s_axis_tuser  <= t.referee_valid;
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		burst_left--;
		want = known ? want : limit_drives(t);
		if (known)
			void'(limit_drives(t));
		limited_q.push_back(want);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (limited_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [clp_pkg::CFG_IDX_W-1:0] idx,
		input logic [clp_pkg::MAXD_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			clp_pkg::REG_MAX_TOTAL: cap_max   = data;
			clp_pkg::REG_WARN:      warn_lvl  = data[clp_pkg::WARN_W-1:0];
			clp_pkg::REG_INV_LIMIT: tol_ticks = data[clp_pkg::ITL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [clp_pkg::MAXD_W-1:0] max_v,
		input logic [clp_pkg::MAXD_W-1:0] warn_v, input logic [clp_pkg::MAXD_W-1:0] itl_v,
		input bit spare);
		wait_idle();
		write_reg(clp_pkg::REG_MAX_TOTAL, max_v);
		write_reg(clp_pkg::REG_WARN, warn_v);
		write_reg(clp_pkg::REG_INV_LIMIT, itl_v);
		if (spare)
			write_reg(REG_SPARE, clp_pkg::MAXD_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin : rx_side
		limited_t want;
		int       w;
		if (m_axis_tvalid && m_axis_tready) begin
			if (limited_q.size() == 0) begin
				$error("result with nothing pending: tdata %h tuser %b",
					m_axis_tdata, m_axis_tuser);
				fails++;
			end else begin
				want = limited_q.pop_front();
				for (w = 0; w < 4; w++) begin
					if (m_axis_tdata[w*DW +: DW] !== want.cmd[w]) begin
						$error("%s: expected %0d, got %0d", wheel_name[w],
							$signed(want.cmd[w]), $signed(m_axis_tdata[w*DW +: DW]));
						fails++;
					end
				end
				if (m_axis_tuser !== want.was_scaled) begin
					$error("was_scaled: expected %0d, got %0d", want.was_scaled, m_axis_tuser);
					fails++;
				end
			end
		end
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 30) : $urandom_range(5, 60);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN: m_axis_tready <= 1'b1;
			RX_HOLD: m_axis_tready <= 1'b0;
			default: m_axis_tready <= 1'($urandom_range(0, 1));
		endcase
	end

	initial begin : stim
		tick_t    full_inval;
		limited_t none;
		int       k;
		int       ph;
		logic [clp_pkg::MAXD_W-1:0] mx;
		logic [clp_pkg::MAXD_W-1:0] wn;
		logic [clp_pkg::MAXD_W-1:0] it;

		arst_n                   <= 1'b0;
		none                     = '0;
		full_inval               = '0;
		full_inval.drive         = {4{{1'b0, {(DW-1){1'b1}}}}};
		full_inval.referee_valid = 1'b0;

		// reset defaults, limit starts at zero
		dir_rows.push_back(tick_row_known(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(tick_row_known(100, -100, 1, -1, 0, 4095, 0, 0, 0, 0, 1));
		dir_rows.push_back(tick_row_known(32767, -32768, 0, 0, 1, 4095, 19999, -20000, 0, 0, 1));
		dir_rows.push_back(tick_row_known(10000, -10000, 10000, -10000, 1, 672,
			10000, -10000, 10000, -10000, 0));
		dir_rows.push_back(tick_row_known(-32768, -32768, -32768, -32768, 1, 0, 0, 0, 0, 0, 1));
		dir_rows.push_back(tick_row_known(20000, 0, 0, 0, 1, 336, 10000, 0, 0, 0, 1));
		dir_rows.push_back(tick_row(12345, -23456, 345, -4567, 1, 671));
		dir_rows.push_back(tick_row(-1, 1, -32768, 32767, 1, 1));
		dir_rows.push_back(tick_row_known(32767, 32767, 32767, 32767, 1, 4095,
			10000, 10000, 10000, 10000, 1));
		dir_rows.push_back(tick_row_known(-32768, -32768, -32768, -32768, 1, 4095,
			-10000, -10000, -10000, -10000, 1));
		dir_rows.push_back(tick_row(-32768, 32767, -2, 5, 1, 4095));
		// oversized maximum, zero warning level, no invalid tolerance
		dir_rows.push_back(cfg_row(131072, 0, 0));
		dir_rows.push_back(tick_row_known(-32768, -32768, -32768, -32768, 1, 0,
			-32767, -32767, -32767, -32767, 1));
		dir_rows.push_back(tick_row_known(32767, 32767, 0, 0, 0, 0, 16384, 16384, 0, 0, 1));
		dir_rows.push_back(tick_row(100, 200, -300, 400, 0, 2048));
		dir_rows.push_back(tick_row(1000, 1000, 1000, 1000, 1, 4095));
		// zero maximum, top warning level
		dir_rows.push_back(cfg_row(0, 4095, 2));
		dir_rows.push_back(tick_row_known(5, -5, 5, -5, 1, 4095, 0, 0, 0, 0, 1));
		dir_rows.push_back(tick_row(1, 0, 0, 0, 1, 4094));
		dir_rows.push_back(tick_row(7, -7, 0, 0, 0, 0));
		dir_rows.push_back(tick_row(7, -7, 0, 0, 0, 0));
		dir_rows.push_back(tick_row(7, -7, 0, 0, 0, 0));
		dir_rows.push_back(tick_row_known(0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
		// short invalid run holds the limit, longer one falls back
		dir_rows.push_back(cfg_row(40000, 4095, 1));
		dir_rows.push_back(tick_row_known(30000, 0, 0, 0, 1, 4095, 30000, 0, 0, 0, 0));
		dir_rows.push_back(tick_row(30000, 20000, 0, 0, 0, 0));
		dir_rows.push_back(tick_row(30000, 20000, 0, 0, 0, 0));
		dir_rows.push_back(tick_row(0, 0, 0, -32768, 1, 2047));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < dir_rows.size(); k++) begin
			if (dir_rows[k].kind == ROW_CFG)
				program_regs(dir_rows[k].max_v, dir_rows[k].warn_v, dir_rows[k].itl_v, 1'b0);
			else
				send_tick(dir_rows[k].tick, dir_rows[k].known, dir_rows[k].want);
		end

		// invalid ticks against large tolerances hold the limit
		program_regs(100000, 672, 65534, 1'b0);
		repeat (3) send_tick(full_inval, 1'b0, none);
		program_regs(40000, 672, 65535, 1'b0);
		repeat (3) send_tick(full_inval, 1'b0, none);

		for (ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 3))
				0: mx = clp_pkg::MAXD_W'($urandom_range(0, 131072));
				1: mx = clp_pkg::MAXD_W'($urandom);
				2: mx = clp_pkg::MAXD_W'($urandom_range(0, 2000));
				default: mx = 40000;
			endcase
			case ($urandom_range(0, 3))
				0: wn = 1;
				1: wn = clp_pkg::MAXD_W'($urandom_range(1, 4095));
				2: wn = clp_pkg::MAXD_W'($urandom);
				default: wn = clp_pkg::MAXD_W'($urandom_range(200, 1000));
			endcase
			case ($urandom_range(0, 3))
				0: it = clp_pkg::MAXD_W'($urandom_range(0, 5));
				1: it = clp_pkg::MAXD_W'($urandom_range(0, 40));
				2: it = 65534;
				default: it = 65535;
			endcase
			if (ph == 0) begin
				mx = 131072;
				wn = 4095;
				it = 0;
			end else if (ph == 1) begin
				mx = 0;
				wn = 1;
				it = 3;
			end
			program_regs(mx, wn, it, 1'b1);
			repeat (180) send_tick(random_tick(), 1'b0, none);
		end

		wait_idle();
		repeat (150) @(posedge clk);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
